// File: rtl/sctu_pkg.sv
// Shared types, constants and arithmetic helpers of the sine/cosine/tangent unit.
`timescale 1ns / 1ps
package sctu_pkg;

    localparam int ANGLE_W  = 32;
    localparam int FX_W     = 34;
    localparam int MAG_W    = 33;
    localparam int FRAC_IN  = 24;
    localparam int FRAC_FX  = 30;
    localparam int TURN_W   = 5;
    localparam int DIV_BITS = 3;
    localparam int DIV_STG  = 11;
    localparam int NSTG     = 8 + DIV_STG + 1;

    localparam logic [1:0] OP_SIN    = 2'd0;
    localparam logic [1:0] OP_COS    = 2'd1;
    localparam logic [1:0] OP_TAN    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef logic signed [FX_W-1:0] t_fx;
    typedef logic signed [39:0]     t_wide;

    localparam logic [29:0] TURN_RECIP = 30'h28BE60DC;
    localparam logic [63:0] TURN_RND   = 64'd1 << (FRAC_IN + 31);
    localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [MAG_W-1:0] TWO_PI =
        MAG_W'((TWO_PI_Q60 + (64'd1 << (59 - FRAC_FX))) >> (60 - FRAC_FX));
    localparam t_wide HALF_PI =
        t_wide'((HALF_PI_Q60 + (64'd1 << (59 - FRAC_FX))) >> (60 - FRAC_FX));

    localparam logic [63:0] FX_ONE = 64'd1 << FRAC_FX;
    localparam logic [63:0] F2 = 64'd2;
    localparam logic [63:0] F3 = 64'd6;
    localparam logic [63:0] F4 = 64'd24;
    localparam logic [63:0] F5 = 64'd120;
    localparam logic [63:0] F6 = 64'd720;
    localparam logic [63:0] F7 = 64'd5040;
    localparam logic [63:0] F8 = 64'd40320;
    localparam t_fx ONE = t_fx'(FX_ONE);
    localparam t_fx C2  = t_fx'((FX_ONE + F2 / 2) / F2);
    localparam t_fx C3  = t_fx'((FX_ONE + F3 / 2) / F3);
    localparam t_fx C4  = t_fx'((FX_ONE + F4 / 2) / F4);
    localparam t_fx C5  = t_fx'((FX_ONE + F5 / 2) / F5);
    localparam t_fx C6  = t_fx'((FX_ONE + F6 / 2) / F6);
    localparam t_fx C7  = t_fx'((FX_ONE + F7 / 2) / F7);
    localparam t_fx C8  = t_fx'((FX_ONE + F8 / 2) / F8);

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] quo;
        logic [MAG_W-1:0] feed;
    } t_div;

    typedef struct packed {
        logic [1:0]       op;
        t_fx              sc;
        logic             tneg;
        logic             sneg;
        logic             zero;
        logic             ovf;
        logic [MAG_W-1:0] mc;
    } t_tail;

    function automatic t_fx qmul(input t_fx a, input t_fx b);
        logic [MAG_W-1:0]   ma;
        logic [MAG_W-1:0]   mb;
        logic [2*MAG_W-1:0] p;
        logic [2*MAG_W-1:0] rr;
        ma = a[FX_W-1] ? MAG_W'(-a) : MAG_W'(a);
        mb = b[FX_W-1] ? MAG_W'(-b) : MAG_W'(b);
        p  = (2*MAG_W)'(ma) * (2*MAG_W)'(mb);
        rr = (p + ((2*MAG_W)'(1) << (FRAC_FX - 1))) >> FRAC_FX;
        return (a[FX_W-1] ^ b[FX_W-1]) ? -t_fx'(rr) : t_fx'(rr);
    endfunction

    function automatic t_fx fabs(input t_fx a);
        return a[FX_W-1] ? -a : a;
    endfunction

    // {flag, value}
    function automatic logic [ANGLE_W:0] clamp32(input logic neg, input logic [FX_W-1:0] m);
        logic [ANGLE_W:0] res;
        if (neg) begin
            if (m > FX_W'(34'h080000000)) res = {1'b1, 32'h80000000};
            else                          res = {1'b0, ANGLE_W'(-m)};
        end else begin
            if (m > FX_W'(34'h07FFFFFFF)) res = {1'b1, 32'h7FFFFFFF};
            else                          res = {1'b0, m[ANGLE_W-1:0]};
        end
        return res;
    endfunction

    function automatic t_div div_step(input t_div a, input logic [MAG_W-1:0] mc);
        t_div         s;
        logic [MAG_W:0] rem2;
        s = a;
        for (int j = 0; j < DIV_BITS; j++) begin
            rem2   = {s.rem, s.feed[MAG_W-1]};
            s.feed = {s.feed[MAG_W-2:0], 1'b0};
            if (rem2 >= {1'b0, mc}) begin
                s.rem = MAG_W'(rem2 - {1'b0, mc});
                s.quo = {s.quo[MAG_W-2:0], 1'b1};
            end else begin
                s.rem = rem2[MAG_W-1:0];
                s.quo = {s.quo[MAG_W-2:0], 1'b0};
            end
        end
        return s;
    endfunction

endpackage

// File: rtl/sine_cosine_tangent_unit.sv
// Top level: pipelined sine, cosine and tangent of a Q8.24 angle.
// Throughput: one beat per cycle while i_ready holds; per-stage valid bits let bubbles close up under stall.
// Speed is set by the Horner multiplier chain and the 33-bit divider, 3 bits per stage.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
module sine_cosine_tangent_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic signed [31:0] i_angle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_value,
    output logic        o_saturated
);

    localparam int NS = sctu_pkg::NSTG;
    localparam int DS = sctu_pkg::DIV_STG;

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // turn count
    logic [31:0] n_mag;
    logic [63:0] n_prod;
    logic [1:0]  r_s0_op;
    logic        r_s0_neg;
    logic [31:0] r_s0_mag;
    logic [sctu_pkg::TURN_W-1:0] r_s0_turns;

    always_comb begin
        n_mag  = i_angle[31] ? 32'(-i_angle) : 32'(i_angle);
        n_prod = 64'(n_mag) * 64'(sctu_pkg::TURN_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_op    <= i_operation;
            r_s0_neg   <= i_angle[31];
            r_s0_mag   <= n_mag;
            r_s0_turns <= sctu_pkg::TURN_W'((n_prod + sctu_pkg::TURN_RND) >> 56);
        end
    end

    // range reduction and fold
    sctu_pkg::t_wide n_d, n_xr, n_xabs, n_t, n_r;
    logic [1:0]    r_s1_op;
    sctu_pkg::t_fx r_s1_r;
    logic          r_s1_xneg, r_s1_cneg;

    always_comb begin
        n_d    = sctu_pkg::t_wide'({r_s0_mag, 6'b0})
               - sctu_pkg::t_wide'(40'(r_s0_turns) * 40'(sctu_pkg::TWO_PI));
        n_xr   = r_s0_neg ? -n_d : n_d;
        n_xabs = n_xr[39] ? -n_xr : n_xr;
        n_t    = n_xabs - sctu_pkg::HALF_PI;
        n_r    = sctu_pkg::HALF_PI - (n_t[39] ? -n_t : n_t);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_op   <= r_s0_op;
            r_s1_r    <= sctu_pkg::t_fx'(n_r);
            r_s1_xneg <= n_xr[39];
            r_s1_cneg <= (n_xabs >= sctu_pkg::HALF_PI);
        end
    end

    // square
    logic [1:0]    r_s2_op;
    sctu_pkg::t_fx r_s2_r, r_s2_r2;
    logic          r_s2_xneg, r_s2_cneg;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s2_op   <= r_s1_op;
            r_s2_r    <= r_s1_r;
            r_s2_r2   <= sctu_pkg::qmul(r_s1_r, r_s1_r);
            r_s2_xneg <= r_s1_xneg;
            r_s2_cneg <= r_s1_cneg;
        end
    end

    // Horner steps
    logic [1:0]    r_s3_op, r_s4_op, r_s5_op, r_s6_op;
    sctu_pkg::t_fx r_s3_r, r_s4_r, r_s5_r;
    sctu_pkg::t_fx r_s3_r2, r_s4_r2, r_s5_r2;
    sctu_pkg::t_fx r_s3_ps, r_s4_ps, r_s5_ps, r_s6_ps;
    sctu_pkg::t_fx r_s3_pc, r_s4_pc, r_s5_pc, r_s6_pc;
    logic          r_s3_xneg, r_s4_xneg, r_s5_xneg, r_s6_xneg;
    logic          r_s3_cneg, r_s4_cneg, r_s5_cneg, r_s6_cneg;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s3_op   <= r_s2_op;
            r_s3_r    <= r_s2_r;
            r_s3_r2   <= r_s2_r2;
            r_s3_ps   <= sctu_pkg::C5 + sctu_pkg::qmul(r_s2_r2, -sctu_pkg::C7);
            r_s3_pc   <= -sctu_pkg::C6 + sctu_pkg::qmul(r_s2_r2, sctu_pkg::C8);
            r_s3_xneg <= r_s2_xneg;
            r_s3_cneg <= r_s2_cneg;
        end
        if (adv[4]) begin
            r_s4_op   <= r_s3_op;
            r_s4_r    <= r_s3_r;
            r_s4_r2   <= r_s3_r2;
            r_s4_ps   <= -sctu_pkg::C3 + sctu_pkg::qmul(r_s3_r2, r_s3_ps);
            r_s4_pc   <= sctu_pkg::C4 + sctu_pkg::qmul(r_s3_r2, r_s3_pc);
            r_s4_xneg <= r_s3_xneg;
            r_s4_cneg <= r_s3_cneg;
        end
        if (adv[5]) begin
            r_s5_op   <= r_s4_op;
            r_s5_r    <= r_s4_r;
            r_s5_r2   <= r_s4_r2;
            r_s5_ps   <= sctu_pkg::ONE + sctu_pkg::qmul(r_s4_r2, r_s4_ps);
            r_s5_pc   <= -sctu_pkg::C2 + sctu_pkg::qmul(r_s4_r2, r_s4_pc);
            r_s5_xneg <= r_s4_xneg;
            r_s5_cneg <= r_s4_cneg;
        end
        if (adv[6]) begin
            r_s6_op   <= r_s5_op;
            r_s6_ps   <= sctu_pkg::qmul(r_s5_r, r_s5_ps);
            r_s6_pc   <= sctu_pkg::ONE + sctu_pkg::qmul(r_s5_r2, r_s5_pc);
            r_s6_xneg <= r_s5_xneg;
            r_s6_cneg <= r_s5_cneg;
        end
    end

    // sign and divider setup
    sctu_pkg::t_fx         n_sv, n_cv;
    logic [sctu_pkg::MAG_W-1:0] n_ms, n_mc;
    sctu_pkg::t_tail       n_tail0;
    sctu_pkg::t_div        n_div0;
    sctu_pkg::t_tail       r_s7_tail;
    sctu_pkg::t_div        r_s7_div;

    always_comb begin
        n_sv = r_s6_xneg ? -r_s6_ps : r_s6_ps;
        n_cv = r_s6_cneg ? -r_s6_pc : r_s6_pc;
        n_ms = sctu_pkg::MAG_W'(sctu_pkg::fabs(n_sv));
        n_mc = sctu_pkg::MAG_W'(sctu_pkg::fabs(n_cv));
        n_tail0.op   = r_s6_op;
        n_tail0.sc   = (r_s6_op == sctu_pkg::OP_COS) ? n_cv : n_sv;
        n_tail0.tneg = n_sv[sctu_pkg::FX_W-1] ^ n_cv[sctu_pkg::FX_W-1];
        n_tail0.sneg = n_sv[sctu_pkg::FX_W-1];
        n_tail0.zero = (n_mc == '0);
        n_tail0.ovf  = (sctu_pkg::MAG_W'(n_ms[sctu_pkg::MAG_W-1:8]) >= n_mc);
        n_tail0.mc   = n_mc;
        n_div0.rem   = sctu_pkg::MAG_W'(n_ms[sctu_pkg::MAG_W-1:8]);
        n_div0.quo   = '0;
        n_div0.feed  = {n_ms[7:0], 25'b0};
    end

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s7_tail <= n_tail0;
            r_s7_div  <= n_div0;
        end
    end

    // restoring divider
    sctu_pkg::t_tail r_dv_tail [DS];
    sctu_pkg::t_div  r_dv      [DS];

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_dv_tail[0] <= r_s7_tail;
            r_dv[0]      <= sctu_pkg::div_step(r_s7_div, r_s7_tail.mc);
        end
        for (int k = 1; k < DS; k++) begin
            if (adv[8+k]) begin
                r_dv_tail[k] <= r_dv_tail[k-1];
                r_dv[k]      <= sctu_pkg::div_step(r_dv[k-1], r_dv_tail[k-1].mc);
            end
        end
    end

    // result select and saturation
    sctu_pkg::t_tail     n_tl;
    logic [sctu_pkg::FX_W-1:0] n_qr, n_scm;
    logic [32:0]         n_sat_sc, n_sat_tan, n_res;
    logic signed [31:0]  r_value;
    logic                r_sat;

    always_comb begin
        n_tl      = r_dv_tail[DS-1];
        n_qr      = (sctu_pkg::FX_W'(r_dv[DS-1].quo) + sctu_pkg::FX_W'(1)) >> 1;
        n_scm     = (sctu_pkg::FX_W'(sctu_pkg::fabs(n_tl.sc)) + sctu_pkg::FX_W'(32)) >> 6;
        n_sat_sc  = sctu_pkg::clamp32(n_tl.sc[sctu_pkg::FX_W-1], n_scm);
        if (n_tl.zero)
            n_sat_tan = {1'b1, n_tl.sneg ? 32'h80000000 : 32'h7FFFFFFF};
        else if (n_tl.ovf)
            n_sat_tan = {1'b1, n_tl.tneg ? 32'h80000000 : 32'h7FFFFFFF};
        else
            n_sat_tan = sctu_pkg::clamp32(n_tl.tneg, n_qr);
        case (n_tl.op) inside
            sctu_pkg::OP_SIN, sctu_pkg::OP_COS: n_res = {1'b0, n_sat_sc[31:0]};
            sctu_pkg::OP_TAN:                   n_res = n_sat_tan;
            default:                            n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[NS-1]) begin
            r_value <= n_res[31:0];
            r_sat   <= n_res[32];
        end
    end

    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule

// File: rtl/sctu_checker.sv
// Port-level assertions for the sine/cosine/tangent unit, bound to the top level.
`timescale 1ns / 1ps
module sctu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_value,
    input logic        o_saturated
);

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_value == 32'h7FFFFFFF || o_value == 32'h80000000))
        else $error("saturated beat without an extreme value");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while output is empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value) && $stable(o_saturated)))
        else $error("stalled output beat changed");

endmodule

bind sine_cosine_tangent_unit sctu_checker u_sctu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_value     (o_value),
    .o_saturated (o_saturated)
);

// File: bench/sine_cosine_tangent_unit_tb.sv
// Self-checking testbench of the sine/cosine/tangent unit with a fixed-point trig predictor.
`timescale 1ns / 1ps
module sine_cosine_tangent_unit_tb;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } t_trig_result;

    class t_trig_scoreboard;
        t_trig_result pending[$];
        int           errors = 0;

        function automatic logic [63:0] rnd_shr(logic [63:0] m, int s);
            return (m + (64'd1 << (s - 1))) >> s;
        endfunction

        function automatic longint fx_mul(longint a, longint b);
            logic [127:0] p;
            logic [63:0]  ma;
            logic [63:0]  mb;
            longint       r;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            p = {64'd0, ma} * {64'd0, mb};
            p = (p + (128'd1 << 29)) >> 30;
            r = longint'(p[63:0]);
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function automatic longint inv_fact(int n);
            longint f;
            f = 1;
            for (int i = 2; i <= n; i++) f *= i;
            return ((64'd1 << 30) + f / 2) / f;
        endfunction

        function automatic logic [32:0] sat32(logic neg, logic [63:0] m);
            if (neg) begin
                if (m > 64'h80000000) return {1'b1, 32'h80000000};
                return {1'b0, 32'(-m)};
            end
            if (m > 64'h7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
            return {1'b0, m[31:0]};
        endfunction

        function automatic logic [32:0] to_q24(longint v);
            logic [63:0] m;
            m = v < 0 ? -v : v;
            return sat32(v < 0, rnd_shr(m, 6));
        endfunction

        function automatic logic [32:0] tan_q24(longint s, longint c);
            logic [63:0] ms;
            logic [63:0] mc;
            logic [63:0] ip;
            logic [63:0] rem;
            logic [63:0] q;
            logic        neg;
            ms = s < 0 ? -s : s;
            mc = c < 0 ? -c : c;
            neg = (s < 0) != (c < 0);
            if (mc == 0) return {1'b1, (s < 0) ? 32'h80000000 : 32'h7FFFFFFF};
            ip = ms / mc;
            rem = ms % mc;
            if (ip >= 64'd256) return sat32(neg, 64'h100000000);
            q = ip;
            for (int i = 0; i < 25; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= mc) begin
                    rem -= mc;
                    q |= 1;
                end
            end
            return sat32(neg, (q + 1) >> 1);
        endfunction

        function void note(logic [1:0] op, logic [31:0] ang);
            logic        neg;
            logic [63:0] mag;
            logic [63:0] turns;
            logic [63:0] two_pi;
            longint      half_pi;
            longint      d, xr, xabs, t, r, r2, ps, pc, sv, cv;
            logic [32:0] res;
            t_trig_result e;
            neg = ang[31];
            mag = neg ? (64'h100000000 - {32'd0, ang}) : {32'd0, ang};
            turns = (mag * 64'h28BE60DC + (64'd1 << 55)) >> 56;
            two_pi = rnd_shr(64'h6487ED5110B4611A, 30);
            half_pi = longint'(rnd_shr(64'h1921FB54442D1846, 30));
            d = longint'(mag << 6) - longint'(turns * two_pi);
            xr = neg ? -d : d;
            xabs = xr < 0 ? -xr : xr;
            t = xabs - half_pi;
            r = half_pi - (t < 0 ? -t : t);
            r2 = fx_mul(r, r);
            ps = -inv_fact(7);
            ps = inv_fact(5) + fx_mul(r2, ps);
            ps = -inv_fact(3) + fx_mul(r2, ps);
            ps = (longint'(1) << 30) + fx_mul(r2, ps);
            ps = fx_mul(r, ps);
            sv = xr < 0 ? -ps : ps;
            pc = inv_fact(8);
            pc = -inv_fact(6) + fx_mul(r2, pc);
            pc = inv_fact(4) + fx_mul(r2, pc);
            pc = -inv_fact(2) + fx_mul(r2, pc);
            pc = (longint'(1) << 30) + fx_mul(r2, pc);
            cv = xabs >= half_pi ? -pc : pc;
            case (op)
                sctu_pkg::OP_SIN:  res = to_q24(sv);
                sctu_pkg::OP_COS:  res = to_q24(cv);
                sctu_pkg::OP_TAN:  res = tan_q24(sv, cv);
                default:           res = 33'd0;
            endcase
            if (op != sctu_pkg::OP_TAN) res[32] = 1'b0;
            e.value = res[31:0];
            e.sat = res[32];
            pending.push_back(e);
        endfunction

        function void check(logic [31:0] value, logic sat);
            t_trig_result e;
            if (pending.size() == 0) begin
                $error("unexpected result value=%h saturated=%b", value, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $error("value: expected %h actual %h", e.value, value);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %b actual %b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic signed [31:0] i_angle;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_value;
    logic        o_saturated;

    t_trig_scoreboard sb = new();
    bit calm_tx = 0;
    bit calm_rx = 0;

    sine_cosine_tangent_unit DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(logic [1:0] op, logic [31:0] ang);
        int g;
        g = pick_gap(calm_tx);
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_angle <= ang;
        do @(posedge i_clk); while (!o_ready);
        sb.note(op, ang);
    endtask

    function automatic logic [31:0] rand_angle();
        int     k;
        logic [31:0] base;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
            2: begin
                k = $urandom_range(0, 160);
                base = 32'((k - 80) * 26353589);
                return base + 32'($signed($urandom_range(0, 64)) - 32);
            end
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check(o_value, o_saturated);
        if ($urandom_range(0, 199) == 0) calm_rx <= ~calm_rx;
        i_ready <= calm_rx ? 1'b1 : ($urandom_range(0, 99) < 65);
    end

    initial begin
        logic [31:0] dir[] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF,
                               32'd26353589, -32'd26353589, 32'd52707179, -32'd52707179,
                               32'd105414357, 32'd79060768, 32'd26353588};
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_operation = sctu_pkg::OP_SIN;
        i_angle = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir[n]) send_beat(sctu_pkg::OP_TAN, dir[n]);
        send_beat(sctu_pkg::OP_SIN, 32'h7FFFFFFF);
        send_beat(sctu_pkg::OP_COS, 32'h80000000);
        send_beat(sctu_pkg::OP_SIN, 32'd26353589);
        send_beat(sctu_pkg::OP_COS, 32'd52707179);
        send_beat(sctu_pkg::OP_UNUSED, 32'h12345678);
        send_beat(sctu_pkg::OP_UNUSED, 32'hFFFFFFFF);
        for (int n = 0; n < 1700; n++) begin
            if ($urandom_range(0, 149) == 0) calm_tx = ~calm_tx;
            send_beat(($urandom_range(0, 19) == 0) ? sctu_pkg::OP_UNUSED
                                                   : 2'($urandom_range(0, 2)),
                      rand_angle());
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
